### sv/ir_remote_pulse_train_encoder_defines.svh
// Assertion macros for the IR pulse-train encoder checker.
// Used only by the checker file; needs clk and rst_n in scope.
`ifndef IR_REMOTE_PULSE_TRAIN_ENCODER_DEFINES_SVH
`define IR_REMOTE_PULSE_TRAIN_ENCODER_DEFINES_SVH

// Property checked while out of reset.
`define IRPTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define IRPTE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/irpte_pkg.sv
// Types and timing constants for the IR pulse-train encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package irpte_pkg;

  localparam int CODE_W   = 22;
  localparam int FDUR_W   = 17;
  localparam int SDUR_W   = 12;
  localparam int CARR_W   = 10;
  localparam int FRAME_W  = 16;

  // long format, 57 kHz carrier
  localparam int LONG_UNIT  = 833;
  localparam int LONG_GAP   = 120000;
  // short format, 40 kHz carrier
  localparam int SHORT_FRAME = 45000;
  localparam int SHORT_HEAD  = 2660;
  localparam int SHORT_ONE   = 1500;
  localparam int SHORT_ZERO  = 870;
  localparam int SHORT_SPACE = 300;
  localparam int SHORT_AFTER_HEAD = SHORT_FRAME - SHORT_HEAD - SHORT_SPACE;

  localparam int CLOCK_KHZ = 80000;
  localparam int LONG_KHZ  = 57;
  localparam int SHORT_KHZ = 40;
  localparam int LONG_PERIOD  = CLOCK_KHZ / LONG_KHZ;
  localparam int SHORT_PERIOD = CLOCK_KHZ / SHORT_KHZ;
  localparam int LONG_HI  = LONG_PERIOD / 2;
  localparam int LONG_LO  = LONG_PERIOD - LONG_HI;
  localparam int SHORT_HI = SHORT_PERIOD / 2;
  localparam int SHORT_LO = SHORT_PERIOD - SHORT_HI;

  typedef struct packed {
    logic              cmd;
    logic [CODE_W-1:0] code;
  } in_item_t;

  typedef struct packed {
    logic [FDUR_W-1:0] first_duration;
    logic              first_level;
    logic [SDUR_W-1:0] second_duration;
    logic              second_level;
    logic [CARR_W-1:0] carrier_high_ticks;
    logic [CARR_W-1:0] carrier_low_ticks;
    logic              frame_end;
    logic              last;
  } out_item_t;

  // job handed from the front end to the sequencer
  typedef struct packed {
    logic              is_short;
    logic [CODE_W-1:0] code;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/ir_remote_pulse_train_encoder.sv
// IR remote pulse-train encoder, top level: front end, job queue, sequencer.
// Each code word expands to 25 pulse words (long format) or 14 per frame times
// SHORT_REPEATS (short format), one word per cycle from the sequencer while out_stall
// is low. The sequencer takes a new code only after the last word of the one before.
// Synchronous active-low reset clears enable, queue, state.
`timescale 1ns / 1ps

module ir_remote_pulse_train_encoder import irpte_pkg::*; #(
  parameter int LONG_BITS     = 22,
  parameter int SHORT_BITS    = 12,
  parameter int SHORT_REPEATS = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  q_stat_t q_stat;
  logic    push, pop;
  job_t    push_job, pop_job;

  irpte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job)
  );

  irpte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  irpte_back #(
    .LONG_BITS     (LONG_BITS),
    .SHORT_BITS    (SHORT_BITS),
    .SHORT_REPEATS (SHORT_REPEATS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_job   (pop_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/irpte_front.sv
// Front end: enable register, input acceptance and job classification.
// Depends on irpte_pkg.
`timescale 1ns / 1ps

module irpte_front import irpte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     cfg_wdata,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output job_t     push_job
);

  logic en_r;
  logic en_nxt;

  always_comb begin
    en_nxt = en_r;
    if (cfg_we) begin
      en_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= en_nxt;
    end
  end

  // words taken while disabled are dropped on the floor
  assign in_stall          = q_stat.full;
  assign push              = in_valid && !q_stat.full && en_r;
  assign push_job.is_short = in_data.cmd;
  assign push_job.code     = in_data.code;

endmodule

### sv/irpte_queue.sv
// Two-entry job queue between the front end and the sequencer.
// Depends on irpte_pkg.
`timescale 1ns / 1ps

module irpte_queue import irpte_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t q_stat
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_job      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (do_pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### sv/irpte_back.sv
// Back end: pulse-pair sequencer with registered output word.
// Depends on irpte_pkg; takes jobs from irpte_queue.
`timescale 1ns / 1ps

module irpte_back import irpte_pkg::*; #(
  parameter int LONG_BITS     = 22,
  parameter int SHORT_BITS    = 12,
  parameter int SHORT_REPEATS = 3
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  job_t      pop_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int MAXB  = (LONG_BITS > SHORT_BITS) ? LONG_BITS : SHORT_BITS;
  localparam int IDX_W = (MAXB > 1) ? $clog2(MAXB) : 1;
  localparam int REP_W = (SHORT_REPEATS > 1) ? $clog2(SHORT_REPEATS) : 1;

  typedef enum logic [2:0] {S_IDLE, S_HEAD, S_BITS, S_STOP, S_GAP} state_t;

  state_t             state_r, state_nxt;
  logic               short_r, short_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [REP_W-1:0]   rep_r, rep_nxt;
  logic [FRAME_W-1:0] rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               adv;
  logic               cbit;
  logic               done;
  logic [31:0]        code_ext;
  logic [4:0]         idx5;
  logic [FRAME_W-1:0] cost;
  out_item_t          item;

  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // bit positions above the code width read as zero
  assign code_ext = {{(32 - CODE_W){1'b0}}, code_r};
  assign idx5     = 5'(idx_r);
  assign cbit     = code_ext[idx5];
  assign done     = !short_r || (rep_r == REP_W'(SHORT_REPEATS - 1));

  always_comb begin
    item                    = '0;
    item.first_level        = 1'b1;
    item.carrier_high_ticks = short_r ? CARR_W'(SHORT_HI) : CARR_W'(LONG_HI);
    item.carrier_low_ticks  = short_r ? CARR_W'(SHORT_LO) : CARR_W'(LONG_LO);
    cost                    = '0;

    state_nxt     = state_r;
    short_nxt     = short_r;
    code_nxt      = code_r;
    idx_nxt       = idx_r;
    rep_nxt       = rep_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (adv) begin
          out_valid_nxt = 1'b0;
        end
        if (!q_stat.empty) begin
          pop       = 1'b1;
          short_nxt = pop_job.is_short;
          code_nxt  = pop_job.code;
          rep_nxt   = '0;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (adv) begin
          if (short_r) begin
            item.first_duration  = FDUR_W'(SHORT_HEAD);
            item.second_duration = SDUR_W'(SHORT_SPACE);
            idx_nxt              = IDX_W'(SHORT_BITS - 1);
          end else begin
            item.first_duration  = FDUR_W'(LONG_UNIT * 4);
            item.second_duration = SDUR_W'(LONG_UNIT * 4);
            idx_nxt              = IDX_W'(LONG_BITS - 1);
          end
          rem_nxt       = FRAME_W'(SHORT_AFTER_HEAD);
          out_item_nxt  = item;
          out_valid_nxt = 1'b1;
          state_nxt     = S_BITS;
        end
      end
      S_BITS: begin
        if (adv) begin
          if (short_r) begin
            item.first_duration  = cbit ? FDUR_W'(SHORT_ONE) : FDUR_W'(SHORT_ZERO);
            item.second_duration = SDUR_W'(SHORT_SPACE);
          end else begin
            item.first_duration  = FDUR_W'(LONG_UNIT);
            item.second_duration = cbit ? SDUR_W'(LONG_UNIT * 3) : SDUR_W'(LONG_UNIT);
          end
          // frame budget, saturating at zero
          cost    = FRAME_W'(item.first_duration) + FRAME_W'(SHORT_SPACE);
          rem_nxt = (rem_r > cost) ? rem_r - cost : '0;
          out_item_nxt  = item;
          out_valid_nxt = 1'b1;
          if (idx_r == '0) begin
            state_nxt = short_r ? S_GAP : S_STOP;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      S_STOP: begin
        if (adv) begin
          item.first_duration  = FDUR_W'(LONG_UNIT);
          item.second_duration = SDUR_W'(LONG_UNIT * 3);
          out_item_nxt         = item;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_GAP;
        end
      end
      S_GAP: begin
        if (adv) begin
          item.first_duration  = short_r ? FDUR_W'(rem_r) : FDUR_W'(LONG_GAP);
          item.first_level     = 1'b0;
          item.second_duration = '0;
          item.frame_end       = 1'b1;
          item.last            = done;
          out_item_nxt         = item;
          out_valid_nxt        = 1'b1;
          if (done) begin
            state_nxt = S_IDLE;
          end else begin
            rep_nxt   = rep_r + 1'b1;
            state_nxt = S_HEAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rep_r       <= '0;
      idx_r       <= '0;
      rem_r       <= FRAME_W'(SHORT_FRAME);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rep_r       <= rep_nxt;
      idx_r       <= idx_nxt;
      rem_r       <= rem_nxt;
    end
    short_r    <= short_nxt;
    code_r     <= code_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

### sv/irpte_checker.sv
// Port-level checker for the IR pulse-train encoder, bound to the top level.
// Depends on irpte_pkg and ir_remote_pulse_train_encoder_defines.svh.
`timescale 1ns / 1ps
`include "ir_remote_pulse_train_encoder_defines.svh"

module irpte_checker import irpte_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      cfg_we,
  input logic      cfg_wdata,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `IRPTE_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "word valid straight after reset")

  `IRPTE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled word changed")

  `IRPTE_ASSERT(a_last_on_gap, out_valid && out_data.last |-> out_data.frame_end && !out_data.first_level, "last word is not a gap")

  `IRPTE_ASSERT(a_pulse_shape, out_valid && !out_data.frame_end |-> out_data.first_level && (out_data.second_duration != 12'd0) && !out_data.second_level, "bad mark/space word")

endmodule

bind ir_remote_pulse_train_encoder irpte_checker u_irpte_checker (.*);
